### rtl/postfix_stack_evaluator_top_macros.svh
// ---------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication
`define PSE_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("postfix evaluator: same-cycle property violated");

// Next-cycle implication
`define PSE_ASSERT_NXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("postfix evaluator: next-cycle property violated");

`endif

### rtl/pse_pkg.sv
// ---------------------------------------------------------------------------
// Postfix evaluator package
// Types, codes, symbol constants and helpers shared by the evaluator files.
// ---------------------------------------------------------------------------
package pse_pkg;

    // Default number of operand stack entries
    localparam int PSE_STACK_DEPTH = 128;

    // Divider iterations, one quotient bit per cycle
    localparam int DIV_STEPS = 32;

    // Symbol bytes
    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SYM_END,
        SYM_PAREN,
        SYM_OPER,
        SYM_OPND
    } sym_class_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_REM
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_UNDER,
        STAT_OVER,
        STAT_DIVZERO
    } stat_t;

    // Datapath status seen by the controller
    typedef struct packed {
        sym_class_t sym_class;
        op_t        sym_op;
        op_t        cur_op;
        logic       count_zero;
        logic       count_lt2;
        logic       stack_full;
        logic       rhs_zero;
        logic       div_done;
        logic       out_free;
    } dp_stat_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic  push;
        logic  pop_op;
        logic  clear;
        logic  alu_load;
        logic  div_start;
        logic  div_load;
        logic  pend_load;
        stat_t pend_status;
        logic  out_load;
    } dp_cmd_t;

    // Magnitude of a two's complement word
    function automatic word_t mag(word_t v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

### rtl/pse_sym_if.sv
// ---------------------------------------------------------------------------
// Symbol channel
// Valid/ready channel carrying one expression byte per beat.
// ---------------------------------------------------------------------------
interface pse_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_byte;

    modport source (output valid, output symbol_byte, input ready);
    modport sink (input valid, input symbol_byte, output ready);
endinterface

### rtl/pse_res_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one evaluation result per beat.
// ---------------------------------------------------------------------------
interface pse_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

### rtl/postfix_stack_evaluator_top.sv
// ---------------------------------------------------------------------------
// Postfix stack evaluator
// Operands and parentheses are handled on acceptance; + - * go through FETCH,
// / % through FETCH and DIVIDE, one quotient bit per cycle. A result waits in
// the pending register until the output register is free. A new symbol is
// taken only in IDLE, after the last is done. Reset clears the stack count, skip
// flag, controller and output valid; stack memory is not cleared and needs no pass.
// ---------------------------------------------------------------------------
`include "postfix_stack_evaluator_top_macros.svh"

module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::PSE_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    pse_sym_if.sink   symbols,
    pse_res_if.source results
);
    import pse_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (symbols.valid),
        .in_ready (symbols.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pse_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .symbol_byte (symbols.symbol_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .out_value   (results.value),
        .out_status  (results.status)
    );

    // Error results carry a zero value
    `PSE_ASSERT_IMP(a_err_value_zero, results.valid && (results.status != STAT_OK), results.value == 32'sd0)
    // A result never overwrites one still waiting
    `PSE_ASSERT_IMP(a_no_overwrite, cmd.out_load, !results.valid || results.ready)
    // Input stays blocked while the divider runs
    `PSE_ASSERT_NXT(a_div_blocks_input, cmd.div_start, !symbols.ready)

endmodule

### rtl/pse_div.sv
// ---------------------------------------------------------------------------
// Iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module pse_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pse_pkg::word_t dividend,
    input  pse_pkg::word_t divisor,
    output logic          done,
    output pse_pkg::word_t quotient,
    output pse_pkg::word_t remainder
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    word_t            quo_reg;
    word_t            rem_reg;
    word_t            dvs_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;

    logic [32:0] shifted;
    logic [32:0] diff;

    // Trial subtraction for one step
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load magnitudes, then shift in one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg   <= mag(dividend);
            rem_reg   <= '0;
            dvs_reg   <= mag(divisor);
            neg_q_reg <= dividend[31] ^ divisor[31];
            neg_r_reg <= dividend[31];
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    // Restore signs
    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? (32'd0 - rem_reg) : rem_reg;

endmodule

### rtl/pse_dpath.sv
// ---------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack with registered top entry, ALU, divider and result register.
// ---------------------------------------------------------------------------
module pse_dpath #(
    parameter int STACK_DEPTH = pse_pkg::PSE_STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        symbol_byte,
    input  pse_pkg::dp_cmd_t  cmd,
    output pse_pkg::dp_stat_t stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [31:0] out_value,
    output logic [1:0]        out_status
);
    import pse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Entries below the top live in memory; the top entry is in tos_reg
    word_t mem [STACK_DEPTH];

    logic [CW-1:0] count_reg;
    word_t         tos_reg;
    word_t         rd_data_reg;
    op_t           op_reg;
    word_t         pend_value_reg;
    stat_t         pend_status_reg;
    logic          out_valid_reg;
    word_t         out_value_reg;
    stat_t         out_status_reg;

    sym_class_t    sym_class;
    op_t           sym_op;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;
    word_t         alu_res;
    word_t         push_val;
    word_t         prod;
    logic          div_done;
    word_t         div_quo;
    word_t         div_rem;

    // Classify the input symbol
    always_comb
    begin
        sym_class = SYM_OPND;
        sym_op    = OP_ADD;
        unique case (symbol_byte)
            CH_END:    sym_class = SYM_END;
            CH_LPAREN: sym_class = SYM_PAREN;
            CH_RPAREN: sym_class = SYM_PAREN;
            CH_PLUS:
            begin
                sym_class = SYM_OPER;
                sym_op    = OP_ADD;
            end
            CH_MINUS:
            begin
                sym_class = SYM_OPER;
                sym_op    = OP_SUB;
            end
            CH_STAR:
            begin
                sym_class = SYM_OPER;
                sym_op    = OP_MUL;
            end
            CH_SLASH:
            begin
                sym_class = SYM_OPER;
                sym_op    = OP_DIV;
            end
            CH_PCT:
            begin
                sym_class = SYM_OPER;
                sym_op    = OP_REM;
            end
            default:   sym_class = SYM_OPND;
        endcase
    end

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign push_val = {24'd0, symbol_byte} - {24'd0, CH_ZERO};
    assign prod     = rd_data_reg * tos_reg;

    // Add, subtract, multiply on left (memory) and right (top) operands
    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  alu_res = rd_data_reg + tos_reg;
            OP_SUB:  alu_res = rd_data_reg - tos_reg;
            default: alu_res = prod;
        endcase
    end

    // Status to the controller
    always_comb
    begin
        stat.sym_class  = sym_class;
        stat.sym_op     = sym_op;
        stat.cur_op     = op_reg;
        stat.count_zero = (count_reg == '0);
        stat.count_lt2  = (count_reg < CW'(2));
        stat.stack_full = (count_reg == CW'(STACK_DEPTH));
        stat.rhs_zero   = (tos_reg == '0);
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Stack memory: spill the old top on push, fetch left operand on pop
    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg != '0))
        begin
            mem[count_m1[AW-1:0]] <= tos_reg;
        end
        if (cmd.pop_op)
        begin
            rd_data_reg <= mem[count_m2[AW-1:0]];
        end
    end

    // Stack count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            priority if (cmd.clear)
                count_reg <= '0;
            else if (cmd.push)
                count_reg <= count_reg + CW'(1);
            else if (cmd.pop_op)
                count_reg <= count_m1;
            else
                count_reg <= count_reg;
        end
    end

    // Top entry, operator latch and pending result
    always_ff @(posedge clk)
    begin
        priority if (cmd.push)
            tos_reg <= push_val;
        else if (cmd.alu_load)
            tos_reg <= alu_res;
        else if (cmd.div_load)
            tos_reg <= (op_reg == OP_DIV) ? div_quo : div_rem;
        else
            tos_reg <= tos_reg;

        if (cmd.pop_op)
        begin
            op_reg <= sym_op;
        end
        if (cmd.pend_load)
        begin
            pend_value_reg  <= (cmd.pend_status == STAT_OK) ? tos_reg : '0;
            pend_status_reg <= cmd.pend_status;
        end
    end

    // Output register: load a result, drop it when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= pend_value_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    pse_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rd_data_reg),
        .divisor   (tos_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

endmodule

### rtl/pse_ctrl.sv
// ---------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences symbol handling, operand fetch, division and result emission.
// ---------------------------------------------------------------------------
module pse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pse_pkg::dp_stat_t stat,
    output pse_pkg::dp_cmd_t  cmd
);
    import pse_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   skip_reg;
    logic   skip_next;
    logic   accept;
    logic   is_div_op;
    logic   cur_div_op;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign is_div_op  = (stat.sym_op == OP_DIV) || (stat.sym_op == OP_REM);
    assign cur_div_op = (stat.cur_op == OP_DIV) || (stat.cur_op == OP_REM);

    // State and skip flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            skip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            skip_reg  <= skip_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (stat.sym_class == SYM_END)
                        state_next = skip_reg ? ST_IDLE : ST_EMIT;
                    else if (skip_reg || (stat.sym_class == SYM_PAREN))
                        state_next = ST_IDLE;
                    else if (stat.sym_class == SYM_OPND)
                        state_next = stat.stack_full ? ST_EMIT : ST_IDLE;
                    else if (stat.count_lt2 || (is_div_op && stat.rhs_zero))
                        state_next = ST_EMIT;
                    else
                        state_next = ST_FETCH;
                end
            end
            ST_FETCH:
                state_next = cur_div_op ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE:
                if (stat.div_done)
                    state_next = ST_IDLE;
            ST_EMIT:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Commands and skip flag
    always_comb
    begin
        cmd       = '0;
        skip_next = skip_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (stat.sym_class == SYM_END)
                    begin
                        // End of expression: clear the stack; unless skipping, emit top or report empty stack
                        cmd.clear = 1'b1;
                        skip_next = 1'b0;
                        if (!skip_reg)
                        begin
                            cmd.pend_load   = 1'b1;
                            cmd.pend_status = stat.count_zero ? STAT_UNDER : STAT_OK;
                        end
                    end
                    else if (skip_reg || (stat.sym_class == SYM_PAREN))
                    begin
                        // Drop the symbol
                    end
                    else if (stat.sym_class == SYM_OPND)
                    begin
                        if (stat.stack_full)
                        begin
                            cmd.clear       = 1'b1;
                            cmd.pend_load   = 1'b1;
                            cmd.pend_status = STAT_OVER;
                            skip_next       = 1'b1;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (stat.count_lt2)
                    begin
                        cmd.clear       = 1'b1;
                        cmd.pend_load   = 1'b1;
                        cmd.pend_status = STAT_UNDER;
                        skip_next       = 1'b1;
                    end
                    else if (is_div_op && stat.rhs_zero)
                    begin
                        cmd.clear       = 1'b1;
                        cmd.pend_load   = 1'b1;
                        cmd.pend_status = STAT_DIVZERO;
                        skip_next       = 1'b1;
                    end
                    else
                    begin
                        cmd.pop_op = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                if (cur_div_op)
                    cmd.div_start = 1'b1;
                else
                    cmd.alu_load = 1'b1;
            end
            ST_DIVIDE:
                cmd.div_load = stat.div_done;
            ST_EMIT:
                cmd.out_load = stat.out_free;
            default:
            begin
            end
        endcase
    end

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Feeds expression bytes over the symbol channel and scores every result
// beat against a cycle-free predictor of the operand stack. A short directed
// table covers the extremes, all operators, underflow and division by zero. It is
// followed by random well-formed, corrupted, noisy and stack-filling
// expressions, with random idling and back-pressure on both channels.
// ---------------------------------------------------------------------------
module tb;
    import pse_pkg::*;

    localparam int DEPTH          = PSE_STACK_DEPTH;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_SYMBOLS = 450;
    localparam int HOLD_AT        = 200;
    localparam int PAUSE_AT       = 330;

    typedef struct packed {
        word_t value;
        stat_t status;
    } outcome_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       typed;
        outcome_t   outcome;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pse_sym_if sym_ch ();
    pse_res_if res_ch ();

    postfix_stack_evaluator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_ch),
        .results (res_ch)
    );

    // Predictor state
    word_t      calc_stack [DEPTH];
    int         calc_depth = 0;
    bit         calc_skip = 1'b0;

    outcome_t   pending_results [$];
    stim_row_t  directed_rows [$];
    int         symbols_sent = 0;
    int         mismatches = 0;
    bit         sender_calm = 1'b0;
    bit         hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_operator(logic [7:0] sym);
        return sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR ||
               sym == CH_SLASH || sym == CH_PCT;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            3: return CH_SLASH;
            default: return CH_PCT;
        endcase
    endfunction

    // Digits now and then, so that zero divisors turn up
    function automatic logic [7:0] pick_operand();
        logic [7:0] sym;
        if ($urandom_range(0, 4) == 0)
            return CH_ZERO + 8'($urandom_range(0, 9));
        do
            sym = 8'($urandom_range(1, 255));
        while (is_operator(sym) || sym == CH_LPAREN || sym == CH_RPAREN);
        return sym;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Advance the stack model by one symbol
    task automatic evaluate_symbol(input logic [7:0] sym, output bit emitted,
                                   output outcome_t outcome);
        word_t lhs;
        word_t rhs;
        word_t lhs_mag;
        word_t rhs_mag;
        word_t res;
        bit    faulted;
        stat_t fault;
        emitted = 1'b0;
        faulted = 1'b0;
        fault = STAT_OK;
        res = '0;
        outcome.value = '0;
        outcome.status = STAT_OK;
        if (sym == CH_END)
        begin
            // End of expression: report the top unless an error was already sent
            emitted = !calc_skip;
            if (!calc_skip && calc_depth != 0)
                outcome.value = calc_stack[calc_depth - 1];
            else if (!calc_skip)
                outcome.status = STAT_UNDER;
            calc_depth = 0;
            calc_skip = 1'b0;
        end
        else if (calc_skip || sym == CH_LPAREN || sym == CH_RPAREN)
        begin
            // Drop the byte
        end
        else if (!is_operator(sym))
        begin
            if (calc_depth >= DEPTH)
            begin
                faulted = 1'b1;
                fault = STAT_OVER;
            end
            else
            begin
                calc_stack[calc_depth] = word_t'(sym) - 32'd48;
                calc_depth++;
            end
        end
        else if (calc_depth < 2)
        begin
            faulted = 1'b1;
            fault = STAT_UNDER;
        end
        else
        begin
            rhs = calc_stack[calc_depth - 1];
            lhs = calc_stack[calc_depth - 2];
            calc_depth -= 2;
            lhs_mag = lhs[31] ? (32'd0 - lhs) : lhs;
            rhs_mag = rhs[31] ? (32'd0 - rhs) : rhs;
            case (sym)
                CH_PLUS:  res = lhs + rhs;
                CH_MINUS: res = lhs - rhs;
                CH_STAR:  res = lhs * rhs;
                CH_SLASH:
                begin
                    if (rhs == '0)
                        faulted = 1'b1;
                    else
                    begin
                        res = lhs_mag / rhs_mag;
                        if (lhs[31] ^ rhs[31])
                            res = 32'd0 - res;
                    end
                end
                default:
                begin
                    if (rhs == '0)
                        faulted = 1'b1;
                    else
                    begin
                        res = lhs_mag % rhs_mag;
                        if (lhs[31])
                            res = 32'd0 - res;
                    end
                end
            endcase
            if (faulted)
                fault = STAT_DIVZERO;
            else
            begin
                calc_stack[calc_depth] = res;
                calc_depth++;
            end
        end
        // Any error clears the stack and skips to the end byte
        if (faulted)
        begin
            emitted = 1'b1;
            outcome.status = fault;
            calc_depth = 0;
            calc_skip = 1'b1;
        end
    endtask

    // Offer one byte, hold it until accepted, then idle for a random gap unless calm
    task automatic offer_symbol(input logic [7:0] sym, input bit typed,
                                input outcome_t typed_out);
        bit       emitted;
        outcome_t predicted;
        int       gap;
        sym_ch.valid <= 1'b1;
        sym_ch.symbol_byte <= sym;
        do
            @(posedge clk);
        while (sym_ch.ready !== 1'b1);
        symbols_sent++;
        evaluate_symbol(sym, emitted, predicted);
        if (typed || emitted)
        begin
            pending_results.push_back(typed ? typed_out : predicted);
        end
        gap = sender_calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_row(input logic [7:0] sym, input bit typed = 1'b0,
                           input word_t value = '0, input stat_t status = STAT_OK);
        stim_row_t row;
        row.sym = sym;
        row.typed = typed;
        row.outcome.value = value;
        row.outcome.status = status;
        directed_rows.push_back(row);
    endtask

    // One random expression: well-formed, corrupted or plain noise
    task automatic run_expression();
        logic [7:0] expr [$];
        int         shape;
        int         operands;
        int         depth;
        int         pos;
        shape = $urandom_range(0, 99);
        sender_calm = ($urandom_range(0, 3) == 0);
        if (shape < 12)
        begin
            repeat ($urandom_range(1, 8)) expr.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            operands = $urandom_range(1, 6);
            depth = 0;
            while (operands > 0 || depth > 1)
            begin
                if ($urandom_range(0, 9) == 0)
                    expr.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
                if (operands > 0 && (depth < 2 || $urandom_range(0, 1) == 1))
                begin
                    expr.push_back(pick_operand());
                    operands--;
                    depth++;
                end
                else
                begin
                    expr.push_back(pick_operator());
                    depth--;
                end
            end
            // Break some expressions with one random byte
            if (shape < 24)
            begin
                pos = $urandom_range(0, expr.size() - 1);
                expr[pos] = 8'($urandom_range(0, 255));
            end
        end
        expr.push_back(CH_END);
        foreach (expr[i])
            offer_symbol(expr[i], 1'b0, '0);
    endtask

    // Fill the stack to the top; with overflow, push once more and skip
    task automatic run_deep_expression(input bit overflow);
        sender_calm = 1'b0;
        repeat (overflow ? DEPTH + 1 : DEPTH) offer_symbol(pick_operand(), 1'b0, '0);
        if (overflow)
        begin
            offer_symbol(pick_operator(), 1'b0, '0);
            offer_symbol(pick_operand(), 1'b0, '0);
        end
        offer_symbol(CH_END, 1'b0, '0);
    endtask

    task automatic check_result(input word_t value, input logic [1:0] status);
        outcome_t due;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: value %0d status %0d",
                         $signed(value), status);
        end
        else
        begin
            due = pending_results.pop_front();
            if (value !== due.value || status !== due.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: value exp %0d got %0d, status exp %0d got %0d",
                             $signed(due.value), $signed(value), due.status, status);
            end
        end
    endtask

    // Score result beats
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            check_result(res_ch.value, res_ch.status);
    end

    // Drive result ready: random gaps, calm stretches, one long hold-off
    initial
    begin
        int gap;
        int calm;
        calm = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (calm == 0 && $urandom_range(0, 19) == 0)
                    calm = $urandom_range(20, 60);
                if (calm > 0)
                begin
                    calm--;
                    gap = 0;
                end
                else
                    gap = idle_gap();
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Abort when neither channel moves a beat for too long
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sym_ch.valid === 1'b1 && sym_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                stalled = 0;
            else
                stalled++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        int  base;
        bit  hold_done;
        bit  pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        sym_ch.valid <= 1'b0;
        sym_ch.symbol_byte <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End on an empty stack, operator underflow, skip to end
        add_row(CH_END, 1'b1, 32'd0, STAT_UNDER);
        add_row(CH_MINUS, 1'b1, 32'd0, STAT_UNDER);
        add_row(CH_END);
        // Build 128^4 * 8, which wraps to the most negative value
        add_row(8'hB0);
        add_row(8'hB0);
        add_row(CH_STAR);
        add_row(8'hB0);
        add_row(CH_STAR);
        add_row(8'hB0);
        add_row(CH_STAR);
        add_row(8'h38);
        add_row(CH_STAR);
        // -47 + 46 gives -1; most negative / -1 wraps, parentheses ignored
        add_row(8'h01);
        add_row(8'h5E);
        add_row(CH_PLUS);
        add_row(CH_LPAREN);
        add_row(CH_SLASH);
        add_row(CH_RPAREN);
        add_row(CH_END, 1'b1, 32'h8000_0000, STAT_OK);
        // Largest and smallest operands, then remainder by zero and skip
        add_row(8'hFF);
        add_row(8'h01);
        add_row(CH_MINUS);
        add_row(CH_ZERO);
        add_row(CH_PCT, 1'b1, 32'd0, STAT_DIVZERO);
        add_row(8'h33);
        add_row(CH_END);

        foreach (directed_rows[i])
            offer_symbol(directed_rows[i].sym, directed_rows[i].typed,
                         directed_rows[i].outcome);

        base = symbols_sent;
        run_deep_expression(1'b0);
        while (symbols_sent - base < RANDOM_SYMBOLS)
        begin
            // Hold off the result side while symbols keep coming
            if (!hold_done && symbols_sent - base >= HOLD_AT)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            // Overflow the stack, then drain everything before going on
            if (!pause_done && symbols_sent - base >= PAUSE_AT)
            begin
                run_deep_expression(1'b1);
                sym_ch.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
                pause_done = 1'b1;
            end
            run_expression();
        end

        sym_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_sym_if.sv
rtl/pse_res_if.sv
rtl/pse_div.sv
rtl/pse_dpath.sv
rtl/pse_ctrl.sv
rtl/postfix_stack_evaluator_top.sv
test/tb.sv
